// File: rtl/ssb_pkg.sv
// Shared types, constants and the command lookup for the serial sensor bridge.
`default_nettype none

package ssb_pkg;

	localparam int unsigned RespBytes = 6;
	localparam int unsigned AddrW     = 4;
	localparam int unsigned DataW     = 32;

	localparam logic [7:0] CrcInit    = 8'hFF;
	localparam logic [7:0] CrcPoly    = 8'h31;
	localparam logic [7:0] FailByte   = 8'h65;
	localparam logic [7:0] CmdLow     = 8'hF1;
	localparam logic [7:0] CmdHigh    = 8'hFB;

	localparam logic [7:0] RstDevAddr = 8'h31;
	localparam logic [7:0] RstStart   = 8'h55;
	localparam logic [7:0] RstRelease = 8'h66;
	localparam logic [3:0] RstRelCnt  = 4'd3;

	localparam logic       SrcSerial  = 1'b0;
	localparam logic       SrcSensor  = 1'b1;
	localparam logic       DstSensor  = 1'b0;
	localparam logic       DstSerial  = 1'b1;

	typedef enum logic [1:0] {
		REG_DEV_ADDR  = 2'd0,
		REG_START     = 2'd1,
		REG_RELEASE   = 2'd2,
		REG_REL_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_CMD,
		ST_COLLECT,
		ST_CRC,
		ST_EMIT,
		ST_RELEASE
	} phase_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic       destination;
		logic [7:0] out_byte;
		logic       crc_ok;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] start_byte;
		logic [7:0] release_byte;
		logic [3:0] release_count;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic init;
	} crc_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} crc_sts_t;

	// Request code 0xF1..0xFB to sensor command byte
	function automatic logic [7:0] cmd_lookup(input logic [3:0] idx);
		logic [7:0] cmd;
		case (idx)
			4'd0:    cmd = 8'hFD;
			4'd1:    cmd = 8'hF6;
			4'd2:    cmd = 8'hE0;
			4'd3:    cmd = 8'h89;
			4'd4:    cmd = 8'h94;
			4'd5:    cmd = 8'h39;
			4'd6:    cmd = 8'h32;
			4'd7:    cmd = 8'h2F;
			4'd8:    cmd = 8'h24;
			4'd9:    cmd = 8'h1E;
			4'd10:   cmd = 8'h15;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

`default_nettype wire

// File: rtl/ssb_crc.sv
// Bit-serial CRC-8 unit (poly 0x31), one shift step per cycle.
`default_nettype none

module ssb_crc (
	input  logic            clk,
	input  logic            arst_n,
	input  ssb_pkg::crc_ctl_t ctl,
	input  logic [7:0]      data,
	output ssb_pkg::crc_sts_t sts,
	output logic [7:0]      crc
);
	import ssb_pkg::*;

	logic       busy_q;
	logic [2:0] bit_cnt_q;
	logic [7:0] crc_q;
	logic [7:0] step;

	assign step = crc_q[7] ? ({crc_q[6:0], 1'b0} ^ CrcPoly) : {crc_q[6:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q    <= 1'b1;
			bit_cnt_q <= '0;
		end else if (busy_q) begin
			bit_cnt_q <= bit_cnt_q + 3'd1;
			if (bit_cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Fold the new byte in, then shift it through eight steps
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			crc_q <= (ctl.init ? CrcInit : crc_q) ^ data;
		end else if (busy_q) begin
			crc_q <= step;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (bit_cnt_q == 3'd7);
	assign crc      = crc_q;

endmodule

`default_nettype wire

// File: rtl/ssb_regs.sv
// APB-style configuration registers of the serial sensor bridge.
`default_nettype none

module ssb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssb_pkg::AddrW-1:0] paddr,
	input  logic [ssb_pkg::DataW-1:0] pwdata,
	output logic [ssb_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output ssb_pkg::cfg_t             cfg
);
	import ssb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= RstDevAddr;
			cfg_q.start_byte     <= RstStart;
			cfg_q.release_byte   <= RstRelease;
			cfg_q.release_count  <= RstRelCnt;
		end else if (wr_en) begin
			case (idx)
				REG_DEV_ADDR:  cfg_q.device_address <= pwdata[7:0];
				REG_START:     cfg_q.start_byte     <= pwdata[7:0];
				REG_RELEASE:   cfg_q.release_byte   <= pwdata[7:0];
				REG_REL_COUNT: cfg_q.release_count  <= pwdata[3:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEV_ADDR:  prdata = {24'd0, cfg_q.device_address};
			REG_START:     prdata = {24'd0, cfg_q.start_byte};
			REG_RELEASE:   prdata = {24'd0, cfg_q.release_byte};
			REG_REL_COUNT: prdata = {28'd0, cfg_q.release_count};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/serial_sensor_bridge_protocol.sv
// Top level of the serial sensor bridge: frame sequencer, response store, output register.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_stall    | in_item  (operation, byte_value)
//   out      | out_valid / out_stall  | out_item (destination, out_byte, crc_ok, last)
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// Sensor bytes 0, 1, 3 and 4 of a response are accepted and then run through
// eight steps of the single bit-serial CRC unit; other bytes need no such wait.
// The sixth sensor byte releases a burst of six items, one per cycle at best,
// paced by the one output register; no input is taken during the burst.
// Reset clears the sequencer, counters and output valid; configuration returns
// to its reset values. A stalled output holds; a command byte waits on it.
`default_nettype none

module serial_sensor_bridge_protocol (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  ssb_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output ssb_pkg::out_item_t        out_item,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssb_pkg::AddrW-1:0] paddr,
	input  logic [ssb_pkg::DataW-1:0] pwdata,
	output logic [ssb_pkg::DataW-1:0] prdata,
	output logic                      pready
);
	import ssb_pkg::*;

	cfg_t       cfg;
	crc_ctl_t   crc_ctl;
	crc_sts_t   crc_sts;
	logic [7:0] crc_val;

	phase_t     state_q, state_d;
	logic [2:0] resp_cnt_q, resp_cnt_d;
	logic [2:0] emit_cnt_q, emit_cnt_d;
	logic [3:0] rel_run_q, rel_run_d;
	logic [3:0] rel_inc;
	logic       ok_q, ok_d;

	logic [7:0] store_q [RespBytes];
	logic       shift_en;
	logic [7:0] shift_in;

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic       out_free;
	logic       out_load;
	out_item_t  out_d;

	logic       in_accept;
	logic       is_serial;
	logic       is_sensor;
	logic [7:0] b;
	logic       cmd_hit;
	logic       crc_match;
	logic [7:0] cmd_off;

	ssb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (in_item.byte_value),
		.sts    (crc_sts),
		.crc    (crc_val)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign b         = in_item.byte_value;
	assign is_serial = (in_item.operation == SrcSerial);
	assign is_sensor = (in_item.operation == SrcSensor);
	assign cmd_hit   = (b >= CmdLow) && (b <= CmdHigh);
	assign cmd_off   = b - CmdLow;
	assign crc_match = (crc_val == b);
	assign rel_inc   = rel_run_q + 4'd1;

	// Hold input while the CRC unit runs, during a burst, and when a command
	// would find the output register still occupied.
	always_comb begin
		case (state_q)
			ST_CRC, ST_EMIT: in_stall = 1'b1;
			ST_CMD:          in_stall = !out_free;
			default:         in_stall = 1'b0;
		endcase
	end

	assign in_accept = in_valid && !in_stall;

	// Sequencer: next phase, counters and datapath strobes
	always_comb begin
		state_d     = state_q;
		resp_cnt_d  = resp_cnt_q;
		emit_cnt_d  = emit_cnt_q;
		rel_run_d   = rel_run_q;
		ok_d        = ok_q;
		shift_en    = 1'b0;
		shift_in    = b;
		crc_ctl     = '0;
		out_load    = 1'b0;
		out_d       = out_item_q;

		case (state_q)
			ST_IDLE: begin
				if (in_accept && is_serial && b == cfg.start_byte) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				if (in_accept && is_serial) begin
					if (b == cfg.device_address) begin
						state_d = ST_CMD;
					end else begin
						state_d   = ST_RELEASE;
						rel_run_d = '0;
					end
				end
			end
			ST_CMD: begin
				if (in_accept && is_serial) begin
					if (cmd_hit) begin
						// Translate the request into a sensor command
						out_load          = 1'b1;
						out_d.destination = DstSensor;
						out_d.out_byte    = cmd_lookup(cmd_off[3:0]);
						out_d.crc_ok      = 1'b0;
						out_d.last        = 1'b1;
						state_d           = ST_COLLECT;
						resp_cnt_d        = '0;
					end else begin
						state_d   = ST_RELEASE;
						rel_run_d = '0;
					end
				end
			end
			ST_COLLECT: begin
				if (in_accept && is_sensor) begin
					shift_en   = 1'b1;
					resp_cnt_d = resp_cnt_q + 3'd1;
					case (resp_cnt_q)
						3'd2: begin
							ok_d = crc_match;
						end
						3'd5: begin
							ok_d       = ok_q && crc_match;
							resp_cnt_d = '0;
							emit_cnt_d = '0;
							state_d    = ST_EMIT;
						end
						default: begin
							// Data bytes feed the CRC unit; bytes 0 and 3 restart it
							crc_ctl.start = 1'b1;
							crc_ctl.init  = (resp_cnt_q == 3'd0) || (resp_cnt_q == 3'd3);
							state_d       = ST_CRC;
						end
					endcase
				end
			end
			ST_CRC: begin
				if (crc_sts.done) begin
					state_d = ST_COLLECT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					// Rotate the store so its head is always the next byte
					out_load          = 1'b1;
					shift_en          = 1'b1;
					shift_in          = store_q[0];
					out_d.destination = DstSerial;
					out_d.out_byte    = ok_q ? store_q[0] : FailByte;
					out_d.crc_ok      = ok_q;
					out_d.last        = (emit_cnt_q == 3'(RespBytes - 1));
					emit_cnt_d        = emit_cnt_q + 3'd1;
					if (emit_cnt_q == 3'(RespBytes - 1)) begin
						state_d    = ST_RELEASE;
						rel_run_d  = '0;
						emit_cnt_d = '0;
					end
				end
			end
			ST_RELEASE: begin
				if (in_accept && is_serial) begin
					if (b == cfg.release_byte) begin
						if (rel_inc >= cfg.release_count) begin
							state_d   = ST_IDLE;
							rel_run_d = '0;
						end else begin
							rel_run_d = rel_inc;
						end
					end else begin
						rel_run_d = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			resp_cnt_q <= '0;
			emit_cnt_q <= '0;
			rel_run_q  <= '0;
		end else begin
			state_q    <= state_d;
			resp_cnt_q <= resp_cnt_d;
			emit_cnt_q <= emit_cnt_d;
			rel_run_q  <= rel_run_d;
		end
	end

	// Check flag and response shift line carry payload only
	always_ff @(posedge clk) begin
		ok_q <= ok_d;
		if (shift_en) begin
			for (int i = 0; i < RespBytes - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[RespBytes-1] <= shift_in;
		end
	end

	// Output register: drop the item once taken, load the next when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// The CRC unit is busy exactly while the sequencer waits on it
	a_crc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC) == crc_sts.busy)
		else $error("CRC unit busy flag out of step with sequencer");

	// Response and burst counters stay within one response
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(resp_cnt_q < 3'(RespBytes)) && (emit_cnt_q < 3'(RespBytes)))
		else $error("response counter out of range");

	// A burst starts on the sixth sensor byte and always ends with a last item
	a_burst_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_load && emit_cnt_q == 3'(RespBytes - 1))
		|=> (out_valid && out_item.last && state_q == ST_RELEASE))
		else $error("burst ended without a last item");

endmodule

`default_nettype wire
